// File: rtl/arpr_pkg.sv
// Shared types and constants for the ARP request responder.
package arpr_pkg;

	localparam logic [1:0] MODE_FRAME  = 2'd0;
	localparam logic [1:0] MODE_IP_WR  = 2'd1;
	localparam logic [1:0] MODE_MAC_WR = 2'd2;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_IP_WR  = 2'd1;
	localparam logic [1:0] CMD_MAC_WR = 2'd2;

	localparam logic [5:0]  ARP_LAST_IDX   = 6'd41;
	localparam logic [5:0]  POS_MAX        = 6'd63;
	localparam logic [15:0] ETHTYPE_ARP    = 16'h0806;
	localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

	localparam int CMD_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [1:0]  client_index;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  matched_client;
		logic [47:0] reply_eth_dst;
		logic [47:0] reply_src_mac;
		logic [31:0] reply_sender_ip;
		logic [47:0] reply_target_mac;
		logic [31:0] reply_target_ip;
	} out_item_t;

	// Lookup carries the captured request; table writes use client, target_ip or mac.
	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  client;
		logic [47:0] eth_dst;
		logic [47:0] target_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [47:0] mac;
	} cmd_t;

endpackage

// File: rtl/arpr_parser.sv
// Front end: frame byte parser and command generator.
module arpr_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  arpr_pkg::in_item_t item,
	output logic             cmd_push,
	output arpr_pkg::cmd_t   cmd
);
	import arpr_pkg::*;

	logic [5:0]  pos_q;
	logic [47:0] src_mac_q, src_mac_n;
	logic [15:0] type_q, type_n;
	logic [15:0] opcode_q, opcode_n;
	logic [47:0] snd_mac_q, snd_mac_n;
	logic [31:0] snd_ip_q, snd_ip_n;
	logic [31:0] tgt_ip_q, tgt_ip_n;
	logic        frame_take;
	logic [7:0]  b;

	assign b          = item.data_byte;
	assign frame_take = take && (item.mode == MODE_FRAME);

	always_comb begin
		src_mac_n = src_mac_q;
		type_n    = type_q;
		opcode_n  = opcode_q;
		snd_mac_n = snd_mac_q;
		snd_ip_n  = snd_ip_q;
		tgt_ip_n  = tgt_ip_q;
		unique case (pos_q) inside
			[6'd6:6'd11]:   src_mac_n = {src_mac_q[39:0], b};
			[6'd12:6'd13]:  type_n    = {type_q[7:0], b};
			[6'd20:6'd21]:  opcode_n  = {opcode_q[7:0], b};
			[6'd22:6'd27]:  snd_mac_n = {snd_mac_q[39:0], b};
			[6'd28:6'd31]:  snd_ip_n  = {snd_ip_q[23:0], b};
			[6'd38:6'd41]:  tgt_ip_n  = {tgt_ip_q[23:0], b};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			src_mac_q <= '0;
			type_q    <= '0;
			opcode_q  <= '0;
			snd_mac_q <= '0;
			snd_ip_q  <= '0;
			tgt_ip_q  <= '0;
		end else if (frame_take) begin
			src_mac_q <= src_mac_n;
			type_q    <= type_n;
			opcode_q  <= opcode_n;
			snd_mac_q <= snd_mac_n;
			snd_ip_q  <= snd_ip_n;
			tgt_ip_q  <= tgt_ip_n;
			if (item.last_byte)
				pos_q <= '0;
			else if (pos_q < POS_MAX)
				pos_q <= pos_q + 6'd1;
		end
	end

	always_comb begin
		cmd_push       = 1'b0;
		cmd.op         = CMD_LOOKUP;
		cmd.client     = item.client_index;
		cmd.eth_dst    = src_mac_n;
		cmd.target_mac = snd_mac_n;
		cmd.sender_ip  = snd_ip_n;
		cmd.target_ip  = tgt_ip_n;
		cmd.mac        = item.mac_addr;
		if (take) begin
			unique case (item.mode)
				MODE_FRAME: begin
					cmd_push = item.last_byte && (pos_q >= ARP_LAST_IDX)
						&& (type_n == ETHTYPE_ARP) && (opcode_n == OPCODE_REQUEST);
				end
				MODE_IP_WR: begin
					cmd_push      = 1'b1;
					cmd.op        = CMD_IP_WR;
					cmd.target_ip = item.ip_addr;
				end
				MODE_MAC_WR: begin
					cmd_push = 1'b1;
					cmd.op   = CMD_MAC_WR;
				end
				default: ;
			endcase
		end
	end

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		frame_take && item.last_byte |=> pos_q == '0)
		else $error("position not cleared after end of frame");

endmodule

// File: rtl/arpr_cmd_fifo.sv
// Short command queue between the parser and the table back end.
module arpr_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  arpr_pkg::cmd_t wr_data,
	input  logic           rd,
	output logic           full,
	output logic           empty,
	output arpr_pkg::cmd_t rd_data
);
	import arpr_pkg::*;

	localparam int PW = $clog2(CMD_DEPTH);
	localparam int CW = $clog2(CMD_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(CMD_DEPTH - 1);

	cmd_t          mem [CMD_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = count_q == CW'(CMD_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not follow a lone write");

endmodule

// File: rtl/arpr_table.sv
// Back end: client table, lookup and reply register.
module arpr_table #(
	parameter int CLIENTS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  arpr_pkg::cmd_t    cmd,
	output logic              cmd_take,
	input  logic              pop,
	output logic              out_valid,
	output arpr_pkg::out_item_t reply
);
	import arpr_pkg::*;

	localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

	logic [31:0] ip_q  [CLIENTS];
	logic [47:0] mac_q [CLIENTS];
	logic        out_valid_q;
	out_item_t   reply_q;
	logic        pop_fire;
	logic        hit;
	logic [IW-1:0] hit_idx;
	logic [47:0] hit_mac;

	assign pop_fire  = pop && out_valid_q;
	assign cmd_take  = cmd_valid && (cmd.op != CMD_LOOKUP || !out_valid_q || pop_fire);
	assign out_valid = out_valid_q;
	assign reply     = reply_q;

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		hit_mac = mac_q[0];
		for (int i = CLIENTS - 1; i >= 0; i--) begin
			if (ip_q[i] == cmd.target_ip) begin
				hit     = 1'b1;
				hit_idx = IW'(i);
				hit_mac = mac_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLIENTS; i++) begin
				ip_q[i]  <= '0;
				mac_q[i] <= '0;
			end
		end else if (cmd_take) begin
			for (int i = 0; i < CLIENTS; i++) begin
				if (32'(cmd.client) == 32'(i)) begin
					if (cmd.op == CMD_IP_WR)
						ip_q[i] <= cmd.target_ip;
					if (cmd.op == CMD_MAC_WR)
						mac_q[i] <= cmd.mac;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_take && cmd.op == CMD_LOOKUP && hit) begin
			out_valid_q <= 1'b1;
		end else if (pop_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.op == CMD_LOOKUP && hit) begin
			reply_q.matched_client   <= 2'(hit_idx);
			reply_q.reply_eth_dst    <= cmd.eth_dst;
			reply_q.reply_src_mac    <= hit_mac;
			reply_q.reply_sender_ip  <= cmd.target_ip;
			reply_q.reply_target_mac <= cmd.target_mac;
			reply_q.reply_target_ip  <= cmd.sender_ip;
		end
	end

	a_lookup_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take && cmd.op == CMD_LOOKUP |-> !out_valid_q || pop)
		else $error("lookup taken with reply register occupied");

endmodule

// File: rtl/arp_request_responder.sv
// Top level of the ARP request responder.
// Frame bytes and table writes enter one per cycle while full is low; full rises only when the reply
// register is held by the consumer and two further commands are waiting. The front end parses each
// frame byte in the cycle it is transferred; on the last byte of a request of at least 42 bytes it
// queues a lookup in a two-entry command queue, which also carries table writes so they keep their
// order. The back end retires one command per cycle unless a lookup waits for the reply register,
// matching the target IP against every client entry at once and loading a hit into a one-entry reply register.
module arp_request_responder #(
	parameter int CLIENTS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  arpr_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output arpr_pkg::out_item_t reply
);
	import arpr_pkg::*;

	logic take;
	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic q_empty;
	logic cmd_take;
	logic out_valid;

	assign take  = push && !full;
	assign empty = !out_valid;

	arpr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	arpr_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd_in),
		.rd      (cmd_take),
		.full    (full),
		.empty   (q_empty),
		.rd_data (cmd_head)
	);

	arpr_table #(
		.CLIENTS (CLIENTS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (cmd_head),
		.cmd_take  (cmd_take),
		.pop       (pop),
		.out_valid (out_valid),
		.reply     (reply)
	);

endmodule

// File: bench/arp_reply_sb_pkg.sv
// Scoreboard class for the ARP request responder: reply prediction and reply checking.
`timescale 1ns / 100ps

package arp_reply_sb_pkg;

	import arpr_pkg::*;

	localparam int NUM_CLIENTS = 4;
	localparam logic [1:0] MODE_NONE = 2'd3;

	class arp_reply_scoreboard;

		logic [5:0]  pos;
		logic [47:0] src_mac;
		logic [15:0] eth_type;
		logic [15:0] opcode;
		logic [47:0] snd_mac;
		logic [31:0] snd_ip;
		logic [31:0] tgt_ip;
		logic [31:0] ip_tab [NUM_CLIENTS];
		logic [47:0] mac_tab [NUM_CLIENTS];
		out_item_t   replies_due [$];
		int          errors;
		int          checked;

		function new();
			pos = '0;
			src_mac = '0;
			eth_type = '0;
			opcode = '0;
			snd_mac = '0;
			snd_ip = '0;
			tgt_ip = '0;
			for (int i = 0; i < NUM_CLIENTS; i++) begin
				ip_tab[i] = '0;
				mac_tab[i] = '0;
			end
			errors = 0;
			checked = 0;
		endfunction

		// Called once per accepted input transfer.
		function void predict_reply(in_item_t it);
			logic [5:0] idx;
			logic [7:0] b;
			int         hit;
			out_item_t  exp;
			if (it.mode == MODE_IP_WR) begin
				if (it.client_index < NUM_CLIENTS)
					ip_tab[it.client_index] = it.ip_addr;
				return;
			end
			if (it.mode == MODE_MAC_WR) begin
				if (it.client_index < NUM_CLIENTS)
					mac_tab[it.client_index] = it.mac_addr;
				return;
			end
			if (it.mode != MODE_FRAME)
				return;
			idx = pos;
			b = it.data_byte;
			if (idx >= 6 && idx <= 11)
				src_mac = {src_mac[39:0], b};
			else if (idx == 12 || idx == 13)
				eth_type = {eth_type[7:0], b};
			else if (idx == 20 || idx == 21)
				opcode = {opcode[7:0], b};
			else if (idx >= 22 && idx <= 27)
				snd_mac = {snd_mac[39:0], b};
			else if (idx >= 28 && idx <= 31)
				snd_ip = {snd_ip[23:0], b};
			else if (idx >= 38 && idx <= 41)
				tgt_ip = {tgt_ip[23:0], b};
			if (!it.last_byte) begin
				if (pos != POS_MAX)
					pos = pos + 6'd1;
				return;
			end
			pos = '0;
			if (idx < ARP_LAST_IDX || eth_type != ETHTYPE_ARP || opcode != OPCODE_REQUEST)
				return;
			hit = -1;
			for (int i = NUM_CLIENTS - 1; i >= 0; i--)
				if (ip_tab[i] == tgt_ip)
					hit = i;
			if (hit < 0)
				return;
			exp.matched_client = 2'(hit);
			exp.reply_eth_dst = src_mac;
			exp.reply_src_mac = mac_tab[hit];
			exp.reply_sender_ip = tgt_ip;
			exp.reply_target_mac = snd_mac;
			exp.reply_target_ip = snd_ip;
			replies_due.push_back(exp);
		endfunction

		function void compare_field(string name, logic [47:0] exp, logic [47:0] act);
			if (exp !== act) begin
				$error("%s: expected %h, got %h", name, exp, act);
				errors++;
			end
		endfunction

		// Called once per accepted reply transfer.
		function void check_reply(out_item_t got);
			out_item_t exp;
			if (replies_due.size() == 0) begin
				$error("reply with none pending: client %0d sender_ip %h",
					got.matched_client, got.reply_sender_ip);
				errors++;
				return;
			end
			exp = replies_due.pop_front();
			checked++;
			compare_field("matched_client", 48'(exp.matched_client), 48'(got.matched_client));
			compare_field("reply_eth_dst", exp.reply_eth_dst, got.reply_eth_dst);
			compare_field("reply_src_mac", exp.reply_src_mac, got.reply_src_mac);
			compare_field("reply_sender_ip", 48'(exp.reply_sender_ip), 48'(got.reply_sender_ip));
			compare_field("reply_target_mac", exp.reply_target_mac, got.reply_target_mac);
			compare_field("reply_target_ip", 48'(exp.reply_target_ip), 48'(got.reply_target_ip));
		endfunction

	endclass

endpackage

// File: bench/tb_arp_request_responder.sv
// Top-level testbench for the ARP request responder: drivers, receiver and run control.
`timescale 1ns / 100ps

module tb_arp_request_responder;

	import arpr_pkg::*;
	import arp_reply_sb_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t reply;

	arp_reply_scoreboard sb = new();

	logic [7:0] frame_buf [$];
	bit         tx_steady;
	bit         rx_steady;
	bit         rx_hold_req;
	int         sent_items;
	int         full_stalls;
	int         frames_sent;

	arp_request_responder #(.CLIENTS(NUM_CLIENTS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.reply  (reply)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic in_item_t rand_item();
		in_item_t it;
		it.mode = 2'($urandom_range(3));
		it.data_byte = 8'($urandom);
		it.last_byte = 1'($urandom);
		it.client_index = 2'($urandom);
		it.ip_addr = $urandom;
		it.mac_addr = {16'($urandom), $urandom};
		return it;
	endfunction

	function automatic logic [31:0] pick_target();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return sb.ip_tab[$urandom_range(NUM_CLIENTS - 1)];
		else if (r < 80)
			return 32'h0;
		return $urandom;
	endfunction

	function automatic int rand_len();
		if ($urandom_range(99) < 90)
			return 42 + $urandom_range(18);
		return 60 + $urandom_range(12);
	endfunction

	task automatic send_item(input in_item_t it);
		while (!tx_steady && $urandom_range(99) < 20) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		sb.predict_reply(it);
		if (it.mode != MODE_NONE)
			sent_items++;
	endtask

	task automatic write_ip(input int ci, input logic [31:0] ip);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_IP_WR;
		it.client_index = 2'(ci);
		it.ip_addr = ip;
		send_item(it);
	endtask

	task automatic write_mac(input int ci, input logic [47:0] mac);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_MAC_WR;
		it.client_index = 2'(ci);
		it.mac_addr = mac;
		send_item(it);
	endtask

	task automatic send_unused();
		in_item_t it;
		it = rand_item();
		it.mode = MODE_NONE;
		send_item(it);
	endtask

	task automatic send_table_write();
		int          r;
		int          ci;
		logic [31:0] ip;
		ci = $urandom_range(NUM_CLIENTS - 1);
		if ($urandom_range(1)) begin
			write_mac(ci, {16'($urandom), $urandom});
		end else begin
			r = $urandom_range(99);
			if (r < 60)
				ip = $urandom;
			else if (r < 75)
				ip = sb.ip_tab[$urandom_range(NUM_CLIENTS - 1)];
			else if (r < 85)
				ip = 32'h0;
			else
				ip = 32'hFFFF_FFFF;
			write_ip(ci, ip);
		end
	endtask

	task automatic build_frame(input int len, input logic [15:0] etype, input logic [15:0] op,
			input logic [31:0] tip);
		logic [7:0] b;
		frame_buf.delete();
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 12 || i == 13)
				b = etype[8*(13-i) +: 8];
			else if (i == 20 || i == 21)
				b = op[8*(21-i) +: 8];
			else if (i >= 38 && i <= 41)
				b = tip[8*(41-i) +: 8];
			frame_buf.push_back(b);
		end
	endtask

	// Optionally slips table writes between frame bytes.
	task automatic send_frame(input bit mix);
		in_item_t it;
		for (int i = 0; i < frame_buf.size(); i++) begin
			if (mix && $urandom_range(99) < 3)
				send_table_write();
			it = rand_item();
			it.mode = MODE_FRAME;
			it.data_byte = frame_buf[i];
			it.last_byte = (i == frame_buf.size() - 1);
			send_item(it);
		end
		frames_sent++;
	endtask

	task automatic request(input int len, input logic [31:0] tip, input bit mix);
		build_frame(len, ETHTYPE_ARP, OPCODE_REQUEST, tip);
		send_frame(mix);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_reply(reply);
			if (rx_hold_req) begin
				hold_left = 400;
				rx_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= rx_steady || ($urandom_range(99) >= 20);
			end
		end
	end

	initial begin : tx_side
		int r;
		int waited;
		bit held;
		bit paused;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold_req = 1'b0;
		sent_items = 0;
		full_stalls = 0;
		frames_sent = 0;
		held = 1'b0;
		paused = 1'b0;
		arst_n <= 1'b0;
		push <= 1'b0;
		item <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unwritten entries hold zero, so target 0 hits client 0
		request(42, 32'h0, 1'b0);
		write_ip(0, 32'hFFFF_FFFF);
		write_mac(0, 48'hFFFF_FFFF_FFFF);
		write_ip(1, 32'hC0A8_0001);
		write_mac(1, 48'h0);
		write_ip(2, 32'hC0A8_0001);
		write_mac(2, 48'h0200_0000_0002);
		write_ip(3, 32'h0A00_0003);
		write_mac(3, 48'hA5A5_5A5A_A5A5);
		request(42, 32'hFFFF_FFFF, 1'b0);
		request(42, 32'hC0A8_0001, 1'b0);
		request(41, 32'h0A00_0003, 1'b0);
		request(70, 32'h0A00_0003, 1'b0);
		build_frame(42, ETHTYPE_ARP, 16'h0002, 32'hFFFF_FFFF);
		send_frame(1'b0);
		build_frame(42, 16'h0800, OPCODE_REQUEST, 32'hFFFF_FFFF);
		send_frame(1'b0);
		request(1, 32'h0, 1'b0);
		request(42, 32'h1234_5678, 1'b0);
		send_unused();
		request(42, 32'hC0A8_0001, 1'b1);
		write_ip(1, 32'h0);
		request(50, 32'h0, 1'b0);
		drain();

		while (sent_items < 1950) begin
			tx_steady = (sent_items >= 700 && sent_items < 1000);
			rx_steady = tx_steady;
			if (!held && sent_items >= 1200) begin
				held = 1'b1;
				rx_hold_req = 1'b1;
				repeat (12) request(42, sb.ip_tab[0], 1'b0);
			end
			if (!paused && sent_items >= 1500) begin
				paused = 1'b1;
				drain();
			end
			r = $urandom_range(99);
			if (r < 65) begin
				request(rand_len(), pick_target(), 1'b1);
			end else if (r < 75) begin
				send_table_write();
			end else if (r < 82) begin
				build_frame(rand_len(), ($urandom_range(1) ? ETHTYPE_ARP : 16'($urandom)),
					($urandom_range(1) ? OPCODE_REQUEST : 16'($urandom)), pick_target());
				send_frame(1'b1);
			end else if (r < 88) begin
				request(1 + $urandom_range(40), pick_target(), 1'b1);
			end else if (r < 91) begin
				send_unused();
			end else begin
				build_frame(1 + $urandom_range(69), 16'($urandom), 16'($urandom), $urandom);
				send_frame(1'b1);
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		push <= 1'b0;
		waited = 0;
		while (sb.replies_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (sb.replies_due.size() != 0) begin
			$error("%0d expected replies never arrived", sb.replies_due.size());
			sb.errors++;
		end
		$display("Run: %0d items in %0d frames plus table writes, %0d replies checked",
			sent_items, frames_sent, sb.checked);
		$display("Input held off by full on %0d cycles", full_stalls);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
